>>> sv/emc_pkg.sv
// ----------------------------------------------------------------------------
// emc_pkg
// Shared constants, register map and types of the muscle-signal envelope block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package emc_pkg;

  // parameter defaults
  localparam int MAX_BASELINE_DEF = 16;
  localparam int MAX_WINDOW_DEF   = 64;
  localparam int SAMPLE_BITS_DEF  = 10;

  // register field widths
  localparam int BLEN_CFG_BITS = 5;
  localparam int BASE_CFG_BITS = 4;
  localparam int WLEN_CFG_BITS = 7;

  // register reset values
  localparam int BLEN_RESET = 15;
  localparam int BASE_RESET = 2;
  localparam int WLEN_RESET = 8;

  // configuration port
  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  localparam logic [1:0] REG_BASELINE_LEN = 2'd0;
  localparam logic [1:0] REG_LOG_BASE     = 2'd1;
  localparam logic [1:0] REG_WINDOW_LEN   = 2'd2;

  // compression
  localparam int LOG_BASE_MIN = 2;
  localparam int LOG_BASE_MAX = 10;
  localparam int COMP_SAT     = 15;
  localparam int COMP_BITS    = 5;

  typedef logic signed [COMP_BITS-1:0] comp_t;

endpackage

>>> sv/emc_ring_mem.sv
// ----------------------------------------------------------------------------
// emc_ring_mem
// Single-port-write, single-port-read synchronous ring memory, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module emc_ring_mem #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/emc_divider.sv
// ----------------------------------------------------------------------------
// emc_divider
// Restoring unsigned divider, one quotient bit per cycle, shared by the
// baseline mean and the envelope average.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module emc_divider #(
  parameter int DW = 14,
  parameter int VW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [DW-1:0] work;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [VW:0]   trial;

  assign trial    = {rem, work[DW-1]};
  assign quotient = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in from the bottom as the dividend shifts out
  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem  <= VW'(trial - {1'b0, dvs});
        work <= {work[DW-2:0], 1'b1};
      end else begin
        rem  <= trial[VW-1:0];
        work <= {work[DW-2:0], 1'b0};
      end
    end
  end

endmodule

>>> sv/emc_int_log.sv
// ----------------------------------------------------------------------------
// emc_int_log
// Iterative integer logarithm: counts how often the base power fits the value,
// one multiply per cycle, saturating; -1 for a base outside the legal range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module emc_int_log
  import emc_pkg::*;
#(
  parameter int VB = 11
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [VB-1:0]            value,
  input  logic [BASE_CFG_BITS-1:0] log_base,
  output logic                     done,
  output comp_t                    result
);

  localparam int PB = VB + BASE_CFG_BITS;

  logic [VB-1:0]            pw;
  logic [VB-1:0]            val;
  logic [BASE_CFG_BITS-1:0] base;
  logic [COMP_BITS-2:0]     k;
  logic                     busy;
  logic [PB-1:0]            prod;

  assign prod = PB'(pw) * PB'(base);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        val  <= value;
        base <= log_base;
        if (log_base < BASE_CFG_BITS'(LOG_BASE_MIN) ||
            log_base > BASE_CFG_BITS'(LOG_BASE_MAX)) begin
          result <= comp_t'(-1);
          done   <= 1'b1;
        end else begin
          pw   <= VB'(1);
          k    <= '0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (prod <= PB'(val) && k != (COMP_BITS-1)'(COMP_SAT)) begin
          pw <= prod[VB-1:0];
          k  <= k + 1'b1;
        end else begin
          result <= comp_t'({1'b0, k});
          busy   <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

>>> sv/emg_envelope_conditioner.sv
// ----------------------------------------------------------------------------
// emg_envelope_conditioner
// Each sample is taken in idle and passes the baseline, mean, log, envelope and
// output states in turn; priming samples return to idle after the baseline state,
// and while the window fills the envelope state is skipped. The divider is DW wide,
// 14 at default sizes. One sample is in flight; the sample channel stalls until idle.
// Synchronous reset restores register defaults and restarts priming; the ring
// memories are not cleared and are only read after being written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module emg_envelope_conditioner
  import emc_pkg::*;
#(
  parameter int MAX_BASELINE = MAX_BASELINE_DEF,
  parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_BITS-1:0]   paddr,
  input  logic [DATA_BITS-1:0]   pwdata,
  output logic [DATA_BITS-1:0]   prdata,
  output logic                   pready,
  // sample channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] sample,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_BITS-1:0] baseline,
  output logic [SAMPLE_BITS-1:0] rectified,
  output comp_t                  compressed,
  output comp_t                  envelope,
  output logic                   envelope_valid
);

  localparam int BLEN_W = $clog2(MAX_BASELINE + 1);
  localparam int BPTR_W = $clog2(MAX_BASELINE);
  localparam int WLEN_W = $clog2(MAX_WINDOW + 1);
  localparam int WPTR_W = $clog2(MAX_WINDOW);
  localparam int BSUM_W = SAMPLE_BITS + BPTR_W;
  localparam int WMAG_W = $clog2(COMP_SAT * MAX_WINDOW + 1);
  localparam int WSUM_W = WMAG_W + 1;
  localparam int DW     = (BSUM_W > WSUM_W) ? BSUM_W : WSUM_W;
  localparam int VW     = (BLEN_W > WLEN_W) ? BLEN_W : WLEN_W;
  localparam int VB     = SAMPLE_BITS + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BASE,
    S_MEAN,
    S_LOG,
    S_ENV,
    S_OUT
  } state_t;

  state_t state;

  logic [BLEN_CFG_BITS-1:0] baseline_len;
  logic [BASE_CFG_BITS-1:0] log_base;
  logic [WLEN_CFG_BITS-1:0] window_len;

  logic [BLEN_W-1:0]        blen;
  logic [WLEN_W-1:0]        wlen;

  logic [SAMPLE_BITS-1:0]   sample_r;
  logic [BPTR_W-1:0]        bptr;
  logic [BPTR_W:0]          bptr_inc;
  logic [BPTR_W-1:0]        bptr_next;
  logic [BSUM_W-1:0]        bsum;
  logic [BSUM_W-1:0]        bsum_prime;
  logic [BSUM_W-1:0]        bsum_roll;
  logic [BLEN_W-1:0]        prime_cnt;
  logic                     priming;

  logic [WPTR_W-1:0]        wptr;
  logic [WPTR_W:0]          wptr_inc;
  logic [WPTR_W-1:0]        wptr_next;
  logic signed [WSUM_W-1:0] wsum;
  logic signed [WSUM_W-1:0] wsum_fill;
  logic signed [WSUM_W-1:0] wsum_roll;
  logic signed [WSUM_W-1:0] comp_ext;
  logic signed [WSUM_W-1:0] wold_ext;
  logic [WSUM_W-1:0]        wmag;
  logic [WLEN_W-1:0]        wfill;
  logic                     wfill_lt;
  logic                     wneg;

  logic [SAMPLE_BITS-1:0]   mean_r;
  logic [SAMPLE_BITS-1:0]   dev_r;
  comp_t                    comp_r;
  comp_t                    env_r;
  logic                     envv_r;

  logic [SAMPLE_BITS-1:0]   mean_c;
  logic [SAMPLE_BITS-1:0]   dev_c;
  logic [COMP_BITS-1:0]     env_mag;
  comp_t                    env_c;

  logic [SAMPLE_BITS-1:0]   bring_rd;
  logic [COMP_BITS-1:0]     wring_rd;

  logic                     accept;
  logic                     cfg_wr;
  logic                     cfg_hit;
  logic [1:0]               cfg_idx;

  logic                     div_start;
  logic [DW-1:0]            div_dividend;
  logic [VW-1:0]            div_divisor;
  logic                     div_done;
  logic [DW-1:0]            div_q;

  logic                     log_start;
  logic [VB-1:0]            log_value;
  logic                     log_done;
  comp_t                    log_result;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_hit = (cfg_idx == REG_BASELINE_LEN) || (cfg_idx == REG_LOG_BASE) ||
                   (cfg_idx == REG_WINDOW_LEN);

  always_comb begin
    unique case (cfg_idx)
      REG_BASELINE_LEN: prdata = DATA_BITS'(baseline_len);
      REG_LOG_BASE:     prdata = DATA_BITS'(log_base);
      REG_WINDOW_LEN:   prdata = DATA_BITS'(window_len);
      default:          prdata = '0;
    endcase
  end

  // effective lengths, clamped to 1..max
  always_comb begin
    if (baseline_len == '0) begin
      blen = BLEN_W'(1);
    end else if (int'(baseline_len) > MAX_BASELINE) begin
      blen = BLEN_W'(MAX_BASELINE);
    end else begin
      blen = BLEN_W'(baseline_len);
    end
    if (window_len == '0) begin
      wlen = WLEN_W'(1);
    end else if (int'(window_len) > MAX_WINDOW) begin
      wlen = WLEN_W'(MAX_WINDOW);
    end else begin
      wlen = WLEN_W'(window_len);
    end
  end

  // ---------------- datapath ----------------
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  assign bptr_inc  = {1'b0, bptr} + 1'b1;
  assign bptr_next = (bptr_inc >= (BPTR_W+1)'(blen)) ? '0 : bptr_inc[BPTR_W-1:0];
  assign wptr_inc  = {1'b0, wptr} + 1'b1;
  assign wptr_next = (wptr_inc >= (WPTR_W+1)'(wlen)) ? '0 : wptr_inc[WPTR_W-1:0];

  assign priming    = prime_cnt < blen;
  assign bsum_prime = bsum + BSUM_W'(sample_r);
  assign bsum_roll  = bsum - BSUM_W'(bring_rd) + BSUM_W'(sample_r);

  assign mean_c    = div_q[SAMPLE_BITS-1:0];
  assign dev_c     = (sample_r >= mean_c) ? sample_r - mean_c : mean_c - sample_r;
  assign log_value = {1'b0, dev_c} + 1'b1;

  assign comp_ext  = WSUM_W'(log_result);
  assign wold_ext  = WSUM_W'($signed(wring_rd));
  assign wsum_fill = wsum + comp_ext;
  assign wsum_roll = wsum - wold_ext + comp_ext;
  assign wmag      = wsum_roll[WSUM_W-1] ? WSUM_W'(-wsum_roll) : WSUM_W'(wsum_roll);
  assign wfill_lt  = wfill < wlen;

  // quotient magnitude does not exceed the saturation value, sign restored here
  assign env_mag = div_q[COMP_BITS-1:0];
  assign env_c   = wneg ? comp_t'(-env_mag) : comp_t'(env_mag);

  assign div_start    = (state == S_BASE && !priming) ||
                        (state == S_LOG && log_done && !wfill_lt);
  assign div_dividend = (state == S_BASE) ? DW'(bsum_roll) : DW'(wmag);
  assign div_divisor  = (state == S_BASE) ? VW'(blen) : VW'(wlen);

  assign log_start = (state == S_MEAN) && div_done;

  // both rings are read when the sample is taken; writes only follow later
  emc_ring_mem #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_BASELINE)
  ) u_baseline_ring (
    .clk     (clk),
    .wr_en   (state == S_BASE),
    .wr_addr (bptr),
    .wr_data (sample_r),
    .rd_en   (accept),
    .rd_addr (bptr),
    .rd_data (bring_rd)
  );

  emc_ring_mem #(
    .WIDTH (COMP_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_window_ring (
    .clk     (clk),
    .wr_en   ((state == S_LOG) && log_done),
    .wr_addr (wptr),
    .wr_data (log_result),
    .rd_en   (accept),
    .rd_addr (wptr),
    .rd_data (wring_rd)
  );

  emc_divider #(
    .DW (DW),
    .VW (VW)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  emc_int_log #(
    .VB (VB)
  ) u_int_log (
    .clk      (clk),
    .rst      (rst),
    .start    (log_start),
    .value    (log_value),
    .log_base (log_base),
    .done     (log_done),
    .result   (log_result)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      baseline_len <= BLEN_CFG_BITS'(BLEN_RESET);
      log_base     <= BASE_CFG_BITS'(BASE_RESET);
      window_len   <= WLEN_CFG_BITS'(WLEN_RESET);
      bptr         <= '0;
      bsum         <= '0;
      prime_cnt    <= '0;
      wptr         <= '0;
      wsum         <= '0;
      wfill        <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            sample_r <= sample;
            state    <= S_BASE;
          end
        end
        S_BASE: begin
          bptr <= bptr_next;
          if (priming) begin
            bsum      <= bsum_prime;
            prime_cnt <= prime_cnt + 1'b1;
            state     <= S_IDLE;
          end else begin
            bsum  <= bsum_roll;
            state <= S_MEAN;
          end
        end
        S_MEAN: begin
          if (div_done) begin
            mean_r <= mean_c;
            dev_r  <= dev_c;
            state  <= S_LOG;
          end
        end
        S_LOG: begin
          if (log_done) begin
            comp_r <= log_result;
            wptr   <= wptr_next;
            if (wfill_lt) begin
              wsum   <= wsum_fill;
              wfill  <= wfill + 1'b1;
              env_r  <= '0;
              envv_r <= 1'b0;
              state  <= S_OUT;
            end else begin
              wsum   <= wsum_roll;
              wneg   <= wsum_roll[WSUM_W-1];
              envv_r <= 1'b1;
              state  <= S_ENV;
            end
          end
        end
        S_ENV: begin
          if (div_done) begin
            env_r <= env_c;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            baseline       <= mean_r;
            rectified      <= dev_r;
            compressed     <= comp_r;
            envelope       <= env_r;
            envelope_valid <= envv_r;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // register write restarts priming; the user must write only while idle, the block does not enforce it
      if (cfg_wr && cfg_hit) begin
        unique case (cfg_idx)
          REG_BASELINE_LEN: baseline_len <= pwdata[BLEN_CFG_BITS-1:0];
          REG_LOG_BASE:     log_base     <= pwdata[BASE_CFG_BITS-1:0];
          REG_WINDOW_LEN:   window_len   <= pwdata[WLEN_CFG_BITS-1:0];
          default: ;
        endcase
        bptr      <= '0;
        bsum      <= '0;
        prime_cnt <= '0;
        wptr      <= '0;
        wsum      <= '0;
        wfill     <= '0;
      end
    end
  end

endmodule
